>>> hdl/lagged_soft_limit_integrator_top_assert.svh
// assertion macros for the lagged soft-limit integrator
// both macros sample on clk_i and are disabled while rst_ni is low
`ifndef LAGGED_SOFT_LIMIT_INTEGRATOR_TOP_ASSERT_SVH
`define LAGGED_SOFT_LIMIT_INTEGRATOR_TOP_ASSERT_SVH

// same-cycle implication
`define LSLI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lsli assertion failed");

// next-cycle implication
`define LSLI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lsli assertion failed");

`endif

>>> hdl/lsli_pkg.sv
// shared widths, constants and register codes of the lagged soft-limit integrator
// no dependencies
package lsli_pkg;

  localparam int PosW     = 31;
  localparam int SpeedW   = 31;
  localparam int RateW    = 17;
  localparam int LagW     = 17;
  localparam int MaxSpdW  = 30;
  localparam int BandW    = 30;
  localparam int DzW      = 16;
  localparam int TsW      = 16;
  localparam int DrvW     = 16;

  localparam int MulAW    = 34;
  localparam int MulBW    = 33;
  localparam int ProdW    = MulAW + MulBW;

  localparam int NumW     = 62;
  localparam int QuotW    = 31;
  localparam int DivSteps = QuotW;
  localparam int CntW     = 5;

  localparam int AddrW    = 5;
  localparam int DataW    = 32;

  localparam logic [RateW-1:0] CenterTarget = 17'd6554;
  localparam logic [RateW-1:0] CenterBlend  = 17'd6554;

  localparam logic signed [SpeedW-1:0] SpeedSat    = 31'sd655360000;
  localparam logic signed [SpeedW-1:0] SpeedSatNeg = -31'sd655360000;

  localparam logic                      CenterModeRst = 1'b0;
  localparam logic [DzW-1:0]            DeadZoneRst   = 16'd0;
  localparam logic [LagW-1:0]           NormalLagRst  = 17'd65536;
  localparam logic [LagW-1:0]           BrakingLagRst = 17'd65536;
  localparam logic [MaxSpdW-1:0]        MaxSpeedRst   = 30'd65536;
  localparam logic signed [PosW-1:0]    MinLimitRst   = -31'sd655360;
  localparam logic signed [PosW-1:0]    MaxLimitRst   = 31'sd655360;
  localparam logic [BandW-1:0]          DampBandRst   = 30'd65536;

  typedef enum logic [2:0] {
    RegCenterMode = 3'd0,
    RegDeadZone   = 3'd1,
    RegNormalLag  = 3'd2,
    RegBrakingLag = 3'd3,
    RegMaxSpeed   = 3'd4,
    RegMinLimit   = 3'd5,
    RegMaxLimit   = 3'd6,
    RegDampBand   = 3'd7
  } reg_idx_e;

endpackage

>>> hdl/lsli_div.sv
// bit-serial restoring divider with quotient capped at all ones
// depends on lsli_pkg
module lsli_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lsli_pkg::NumW-1:0]   num_i,
  input  logic [lsli_pkg::BandW-1:0]  den_i,
  output logic                        done_o,
  output logic [lsli_pkg::QuotW-1:0]  quot_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [lsli_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [lsli_pkg::BandW-1:0]   rem_q, rem_d;
  logic [lsli_pkg::QuotW-1:0]   quo_q, quo_d;
  logic [lsli_pkg::BandW:0]     rem_sh;
  logic [lsli_pkg::BandW:0]     rem_sub;
  logic                         fits;
  logic                         cap;

  assign rem_sh  = {rem_q, quo_q[lsli_pkg::QuotW-1]};
  assign fits    = rem_sh >= {1'b0, den_i};
  assign rem_sub = rem_sh - {1'b0, den_i};
  // quotient overflows the cap when the high part already reaches the divisor
  assign cap     = num_i[lsli_pkg::NumW-1:lsli_pkg::QuotW] >= {1'b0, den_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      cnt_d = '0;
      if (cap) begin
        quo_d  = {lsli_pkg::QuotW{1'b1}};
        done_d = 1'b1;
      end else begin
        rem_d  = num_i[lsli_pkg::NumW-2:lsli_pkg::QuotW];
        quo_d  = num_i[lsli_pkg::QuotW-1:0];
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[lsli_pkg::BandW-1:0] : rem_sh[lsli_pkg::BandW-1:0];
      quo_d = {quo_q[lsli_pkg::QuotW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == lsli_pkg::CntW'(lsli_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> hdl/lagged_soft_limit_integrator_top.sv
// top level of the lagged soft-limit integrator: apb registers, sequencer, shared multiplier
// depends on lsli_pkg, lsli_div and lagged_soft_limit_integrator_top_assert.svh
//
// One request is worked at a time. A centering step inside the dead zone takes the shortest
// path through the sequencer, and a step with the position in a slowdown band takes the
// longest, since the bit-serial divider computes the band speed. All products go through
// one shared 34x33 multiplier with a registered output. in_stall_o is low only while the
// sequencer is idle; a finished result waits in the output register, so the next request
// can be taken while it is held. The user must write configuration only while the block
// is idle; the block itself does not enforce it.
`include "lagged_soft_limit_integrator_top_assert.svh"

module lagged_soft_limit_integrator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lsli_pkg::AddrW-1:0]         paddr,
  input  logic [lsli_pkg::DataW-1:0]         pwdata,
  output logic [lsli_pkg::DataW-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [lsli_pkg::TsW-1:0]           timestep_i,
  input  logic signed [lsli_pkg::DrvW-1:0]   drive_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [lsli_pkg::PosW-1:0]   position_o,
  output logic signed [lsli_pkg::SpeedW-1:0] velocity_o,
  output logic                               overflow_o
);

  typedef enum logic [16:0] {
    StIdle     = 17'h00001,
    StDec      = 17'h00002,
    StRateMul  = 17'h00004,
    StRateUpd  = 17'h00008,
    StRecMul   = 17'h00010,
    StRecUpd   = 17'h00020,
    StSel      = 17'h00040,
    StBandMul  = 17'h00080,
    StDivStart = 17'h00100,
    StDivWait  = 17'h00200,
    StTgtMul   = 17'h00400,
    StTgtUpd   = 17'h00800,
    StLagMul   = 17'h01000,
    StLagUpd   = 17'h02000,
    StIntMul   = 17'h04000,
    StIntUpd   = 17'h08000,
    StDone     = 17'h10000
  } state_e;

  // configuration registers
  logic                                center_mode_q;
  logic [lsli_pkg::DzW-1:0]            dead_zone_q;
  logic [lsli_pkg::LagW-1:0]           normal_lag_q;
  logic [lsli_pkg::LagW-1:0]           braking_lag_q;
  logic [lsli_pkg::MaxSpdW-1:0]        max_speed_q;
  logic signed [lsli_pkg::PosW-1:0]    min_limit_q;
  logic signed [lsli_pkg::PosW-1:0]    max_limit_q;
  logic [lsli_pkg::BandW-1:0]          damp_band_q;
  logic                                cfg_we;
  lsli_pkg::reg_idx_e                  cfg_idx;

  // sequencer and datapath
  state_e                              state_q, state_d;
  logic [lsli_pkg::TsW-1:0]            ts_q, ts_d;
  logic signed [lsli_pkg::DrvW-1:0]    drv_q, drv_d;
  logic                                inside_q, inside_d;
  logic                                hi_sel_q, hi_sel_d;
  logic signed [lsli_pkg::PosW-1:0]    pos_q, pos_d;
  logic signed [lsli_pkg::SpeedW-1:0]  speed_q, speed_d;
  logic [lsli_pkg::RateW-1:0]          rate_q, rate_d;
  logic                                ov_q, ov_d;
  logic [lsli_pkg::LagW-1:0]           lag_q, lag_d;
  logic signed [31:0]                  tgt_q, tgt_d;
  logic [lsli_pkg::QuotW-1:0]          adj_q, adj_d;
  logic signed [lsli_pkg::ProdW-1:0]   prod_q, prod_d;

  // output register
  logic                                out_valid_q, out_valid_d;
  logic signed [lsli_pkg::PosW-1:0]    position_q;
  logic signed [lsli_pkg::SpeedW-1:0]  velocity_q;
  logic                                overflow_q;
  logic                                out_free;

  // combinational helpers
  logic signed [16:0]                  drv_ext;
  logic [16:0]                         drv_mag;
  logic                                inside_w;
  logic                                drv_pos;
  logic signed [31:0]                  pos_ext32;
  logic signed [31:0]                  hi_edge;
  logic signed [31:0]                  lo_edge;
  logic                                near_hi;
  logic                                near_lo;
  logic                                use_hi;
  logic                                use_lo;
  logic signed [31:0]                  lim_ext;
  logic signed [31:0]                  band_dist;
  logic [31:0]                         dist_abs;
  logic [lsli_pkg::BandW-1:0]          band_eff;
  logic signed [17:0]                  rate_err;
  logic signed [lsli_pkg::MulAW-1:0]   pos_ext34;
  logic signed [lsli_pkg::MulAW-1:0]   lag_err;
  logic signed [lsli_pkg::MulAW-1:0]   mul_a;
  logic signed [lsli_pkg::MulBW-1:0]   mul_b;
  logic [lsli_pkg::RateW-1:0]          rate_sum;
  logic [lsli_pkg::PosW-1:0]           rec_pos;
  logic signed [31:0]                  tgt_w;
  logic signed [34:0]                  ns;
  logic signed [34:0]                  sat_in;
  logic signed [34:0]                  sat_lim;
  logic signed [34:0]                  sat_nlim;
  logic                                sat_hi;
  logic                                sat_lo;
  logic signed [lsli_pkg::SpeedW-1:0]  sat_out;
  logic signed [32:0]                  int_pos;
  logic signed [32:0]                  max33;
  logic signed [32:0]                  min33;
  logic signed [32:0]                  clamp_hi;
  logic signed [32:0]                  clamp_pos;
  logic                                div_start;
  logic                                div_done;
  logic [lsli_pkg::QuotW-1:0]          div_quot;

  // apb register file
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = lsli_pkg::reg_idx_e'(paddr[lsli_pkg::AddrW-1:2]);

  always_comb begin
    unique case (cfg_idx)
      lsli_pkg::RegCenterMode: prdata = {31'd0, center_mode_q};
      lsli_pkg::RegDeadZone:   prdata = {16'd0, dead_zone_q};
      lsli_pkg::RegNormalLag:  prdata = {15'd0, normal_lag_q};
      lsli_pkg::RegBrakingLag: prdata = {15'd0, braking_lag_q};
      lsli_pkg::RegMaxSpeed:   prdata = {2'd0, max_speed_q};
      lsli_pkg::RegMinLimit:   prdata = {min_limit_q[lsli_pkg::PosW-1], min_limit_q};
      lsli_pkg::RegMaxLimit:   prdata = {max_limit_q[lsli_pkg::PosW-1], max_limit_q};
      lsli_pkg::RegDampBand:   prdata = {2'd0, damp_band_q};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_mode_q <= lsli_pkg::CenterModeRst;
      dead_zone_q   <= lsli_pkg::DeadZoneRst;
      normal_lag_q  <= lsli_pkg::NormalLagRst;
      braking_lag_q <= lsli_pkg::BrakingLagRst;
      max_speed_q   <= lsli_pkg::MaxSpeedRst;
      min_limit_q   <= lsli_pkg::MinLimitRst;
      max_limit_q   <= lsli_pkg::MaxLimitRst;
      damp_band_q   <= lsli_pkg::DampBandRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lsli_pkg::RegCenterMode: center_mode_q <= pwdata[0];
        lsli_pkg::RegDeadZone:   dead_zone_q   <= pwdata[lsli_pkg::DzW-1:0];
        lsli_pkg::RegNormalLag:  normal_lag_q  <= pwdata[lsli_pkg::LagW-1:0];
        lsli_pkg::RegBrakingLag: braking_lag_q <= pwdata[lsli_pkg::LagW-1:0];
        lsli_pkg::RegMaxSpeed:   max_speed_q   <= pwdata[lsli_pkg::MaxSpdW-1:0];
        lsli_pkg::RegMinLimit:   min_limit_q   <= pwdata[lsli_pkg::PosW-1:0];
        lsli_pkg::RegMaxLimit:   max_limit_q   <= pwdata[lsli_pkg::PosW-1:0];
        lsli_pkg::RegDampBand:   damp_band_q   <= pwdata[lsli_pkg::BandW-1:0];
        default: ;
      endcase
    end
  end

  // drive decode and band selection
  assign drv_ext   = {drv_q[lsli_pkg::DrvW-1], drv_q};
  assign drv_mag   = drv_ext[16] ? (17'd0 - drv_ext) : drv_ext;
  assign inside_w  = drv_mag <= {1'b0, dead_zone_q};
  assign drv_pos   = !drv_q[lsli_pkg::DrvW-1] && (drv_q != '0);

  assign pos_ext32 = {pos_q[lsli_pkg::PosW-1], pos_q};
  assign hi_edge   = {max_limit_q[lsli_pkg::PosW-1], max_limit_q} - {2'b00, damp_band_q};
  assign lo_edge   = {min_limit_q[lsli_pkg::PosW-1], min_limit_q} + {2'b00, damp_band_q};
  assign near_hi   = pos_ext32 > hi_edge;
  assign near_lo   = pos_ext32 < lo_edge;
  assign use_hi    = near_hi && (center_mode_q || drv_pos);
  assign use_lo    = !use_hi && near_lo && (center_mode_q || drv_q[lsli_pkg::DrvW-1]);

  assign lim_ext   = hi_sel_q ? {max_limit_q[lsli_pkg::PosW-1], max_limit_q}
                              : {min_limit_q[lsli_pkg::PosW-1], min_limit_q};
  assign band_dist = lim_ext - pos_ext32;
  assign dist_abs  = band_dist[31] ? (32'd0 - band_dist) : band_dist;
  assign band_eff  = (damp_band_q == '0) ? lsli_pkg::BandW'(1) : damp_band_q;

  // shared multiplier operands
  assign rate_err  = {1'b0, lsli_pkg::CenterTarget} - {1'b0, rate_q};
  assign pos_ext34 = {{3{pos_q[lsli_pkg::PosW-1]}}, pos_q};
  assign lag_err   = {{2{tgt_q[31]}}, tgt_q} - {{3{speed_q[lsli_pkg::SpeedW-1]}}, speed_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      StRateMul: begin
        mul_a = {{16{rate_err[17]}}, rate_err};
        mul_b = {16'd0, lsli_pkg::CenterBlend};
      end
      StRecMul: begin
        mul_a = -pos_ext34;
        mul_b = {16'd0, rate_q};
      end
      StBandMul: begin
        mul_a = {2'b00, dist_abs};
        mul_b = {3'b000, max_speed_q};
      end
      StTgtMul: begin
        mul_a = {3'b000, adj_q};
        mul_b = {{17{drv_q[lsli_pkg::DrvW-1]}}, drv_q};
      end
      StLagMul: begin
        mul_a = lag_err;
        mul_b = {16'd0, lag_q};
      end
      StIntMul: begin
        mul_a = {{3{speed_q[lsli_pkg::SpeedW-1]}}, speed_q};
        mul_b = {17'd0, ts_q};
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // product consumers, all shifts floor
  assign rate_sum = rate_q + prod_q[32:16];
  assign rec_pos  = pos_q + prod_q[46:16];
  assign tgt_w    = prod_q[46:15];
  assign ns       = {{4{speed_q[lsli_pkg::SpeedW-1]}}, speed_q} + {prod_q[49], prod_q[49:16]};

  assign sat_in   = (state_q == StTgtUpd) ? {{3{tgt_w[31]}}, tgt_w} : ns;
  assign sat_lim  = {4'd0, lsli_pkg::SpeedSat};
  assign sat_nlim = -sat_lim;
  assign sat_hi   = sat_in >= sat_lim;
  assign sat_lo   = sat_in <= sat_nlim;
  assign sat_out  = sat_hi ? lsli_pkg::SpeedSat
                  : (sat_lo ? lsli_pkg::SpeedSatNeg : sat_in[lsli_pkg::SpeedW-1:0]);

  assign int_pos   = {{2{pos_q[lsli_pkg::PosW-1]}}, pos_q} + {{2{prod_q[46]}}, prod_q[46:16]};
  assign max33     = {{2{max_limit_q[lsli_pkg::PosW-1]}}, max_limit_q};
  assign min33     = {{2{min_limit_q[lsli_pkg::PosW-1]}}, min_limit_q};
  // max limit first, then min limit wins
  assign clamp_hi  = (int_pos > max33) ? max33 : int_pos;
  assign clamp_pos = (clamp_hi < min33) ? min33 : clamp_hi;

  assign div_start = state_q == StDivStart;
  assign out_free  = !out_valid_q || !out_stall_i;

  lsli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q[lsli_pkg::NumW-1:0]),
    .den_i   (band_eff),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    ts_d        = ts_q;
    drv_d       = drv_q;
    inside_d    = inside_q;
    hi_sel_d    = hi_sel_q;
    pos_d       = pos_q;
    speed_d     = speed_q;
    rate_d      = rate_q;
    ov_d        = ov_q;
    lag_d       = lag_q;
    tgt_d       = tgt_q;
    adj_d       = adj_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          ts_d    = timestep_i;
          drv_d   = drive_i;
          state_d = StDec;
        end
      end
      StDec: begin
        inside_d = inside_w;
        if (center_mode_q) begin
          state_d = StRateMul;
        end else begin
          rate_d = '0;
          if (inside_w) begin
            // decay toward zero is a lag toward a zero target
            tgt_d   = '0;
            lag_d   = normal_lag_q;
            state_d = StLagMul;
          end else begin
            state_d = StSel;
          end
        end
      end
      StRateMul: state_d = StRateUpd;
      StRateUpd: begin
        rate_d  = rate_sum;
        state_d = inside_q ? StRecMul : StSel;
      end
      StRecMul: state_d = StRecUpd;
      StRecUpd: begin
        pos_d   = rec_pos;
        ov_d    = 1'b0;
        state_d = StDone;
      end
      StSel: begin
        hi_sel_d = use_hi;
        lag_d    = (use_hi || use_lo) ? braking_lag_q : normal_lag_q;
        if (use_hi || use_lo) begin
          state_d = StBandMul;
        end else begin
          adj_d   = {1'b0, max_speed_q};
          state_d = StTgtMul;
        end
      end
      StBandMul:  state_d = StDivStart;
      StDivStart: state_d = StDivWait;
      StDivWait: begin
        if (div_done) begin
          adj_d   = div_quot;
          state_d = StTgtMul;
        end
      end
      StTgtMul: state_d = StTgtUpd;
      StTgtUpd: begin
        tgt_d = tgt_w;
        if (center_mode_q) begin
          speed_d = sat_out;
          ov_d    = sat_hi || sat_lo;
          state_d = StIntMul;
        end else begin
          state_d = StLagMul;
        end
      end
      StLagMul: state_d = StLagUpd;
      StLagUpd: begin
        speed_d = sat_out;
        ov_d    = sat_hi || sat_lo;
        state_d = StIntMul;
      end
      StIntMul: state_d = StIntUpd;
      StIntUpd: begin
        pos_d   = clamp_pos[lsli_pkg::PosW-1:0];
        state_d = StDone;
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pos_q       <= '0;
      speed_q     <= '0;
      rate_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      speed_q     <= speed_d;
      rate_q      <= rate_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ts_q     <= ts_d;
    drv_q    <= drv_d;
    inside_q <= inside_d;
    hi_sel_q <= hi_sel_d;
    ov_q     <= ov_d;
    lag_q    <= lag_d;
    tgt_q    <= tgt_d;
    adj_q    <= adj_d;
    prod_q   <= prod_d;
    if (state_q == StDone && out_free) begin
      position_q <= pos_q;
      velocity_q <= speed_q;
      overflow_q <= ov_q;
    end
  end

  assign in_stall_o  = state_q != StIdle;
  assign out_valid_o = out_valid_q;
  assign position_o  = position_q;
  assign velocity_o  = velocity_q;
  assign overflow_o  = overflow_q;

  `LSLI_ASSERT_NEXT(a_pos_above_min, state_q == StIntUpd, pos_q >= min_limit_q)
  `LSLI_ASSERT_IMP(a_rate_bound, 1'b1, rate_q <= lsli_pkg::CenterTarget)
  `LSLI_ASSERT_IMP(a_vel_bound, out_valid_o, (velocity_o <= lsli_pkg::SpeedSat) && (velocity_o >= lsli_pkg::SpeedSatNeg))
  `LSLI_ASSERT_IMP(a_ovf_at_sat, out_valid_o && overflow_o, (velocity_o == lsli_pkg::SpeedSat) || (velocity_o == lsli_pkg::SpeedSatNeg))

endmodule
